// ===== hw/rtl/spfo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper position frame odometer package
// Shared constants, field layout and the pipeline stage record.
// ----------------------------------------------------------------------------
package spfo_pkg;

  // Frame bytes
  localparam logic [7:0] CMD_BYTE = 8'h36;
  localparam logic [7:0] END_BYTE = 8'h6B;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CIRCUMFERENCE  = 4'd1;

  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'd3;
  localparam logic [31:0] CIRCUMFERENCE_RST  = 32'd350011;

  // Motor counts: 65536 per turn, so scaling by 1/turn is a 16-bit shift
  localparam int unsigned TURN_SHIFT = 16;
  localparam logic signed [33:0] TURN_COUNTS = 34'sd65536;
  localparam logic signed [33:0] HALF_TURN   = 34'sd32768;

  // Length limits of the 37-bit signed per-frame length
  localparam logic [49:0] LEN_POS_MAX = 50'h0_000F_FFFF_FFFF;
  localparam logic [49:0] LEN_NEG_MAX = 50'h0_0010_0000_0000;

  // Result tdata layout, lowest bit first
  localparam int unsigned POS_W   = 33;
  localparam int unsigned DELTA_W = 34;
  localparam int unsigned DLEN_W  = 37;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned POS_LSB   = 0;
  localparam int unsigned DELTA_LSB = POS_LSB + POS_W;
  localparam int unsigned DLEN_LSB  = DELTA_LSB + DELTA_W;
  localparam int unsigned TOTAL_LSB = DLEN_LSB + DLEN_W;
  localparam int unsigned RES_W     = TOTAL_LSB + TOTAL_W;

  // Arithmetic pipeline depth behind the frame parser
  localparam int unsigned NUM_STAGES = 7;

  typedef struct packed {
    logic signed [32:0] pos;
    logic               base;
    logic signed [32:0] prev;
    logic signed [33:0] delta;
    logic               neg;
    logic        [33:0] mag;
    logic        [48:0] p_lo;
    logic        [48:0] p_hi;
    logic        [49:0] scaled;
    logic signed [36:0] dlen;
  } stage_t;

endpackage
`default_nettype wire

// ===== hw/rtl/stepper_position_frame_odometer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper position frame odometer
// Parses position replies from a stepper driver out of a UART byte stream and
// turns each good frame into position, wrap-corrected delta, travelled length
// and a running distance total.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+-------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata[7:0] rx_byte
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata 152b, tuser baseline
//  cfg       | in        | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
//  One byte per cycle while s_axis_tready is high. After its end byte is taken,
//  a frame passes the intake, delta, wrap, magnitude, partial product, sum and
//  saturation stages, then the output register, which adds the total. Frames
//  are 8 bytes. Reset clears parser, baseline, total and valids. A held result
//  fills the stages; s_axis_tready drops only when an end byte meets a full
//  first stage. Config always accepts.
//
module stepper_position_frame_odometer_top #(
  parameter int unsigned DISTANCE_WIDTH = 48
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // request stream in: tdata = {rx_byte[7:0]}
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  input  wire logic [7:0]                              s_axis_tdata,
  // result stream out
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // tdata, lowest bit up: position_counts[32:0], delta_counts[66:33],
  //   delta_length_q16[103:67], total_distance_q16[151:104]
  output logic [spfo_pkg::RES_W-1:0]                   m_axis_tdata,
  // tuser: is_baseline
  output logic                                         m_axis_tuser,
  // configuration writes
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [spfo_pkg::CFG_INDEX_W-1:0]        cfg_index_i,
  input  wire logic [31:0]                             cfg_data_i
);

  localparam int unsigned NS = spfo_pkg::NUM_STAGES;

  // Byte positions within a frame
  localparam logic [2:0] IDX_ADDR  = 3'd0;
  localparam logic [2:0] IDX_CMD   = 3'd1;
  localparam logic [2:0] IDX_SIGN  = 3'd2;
  localparam logic [2:0] IDX_MAG0  = 3'd3;
  localparam logic [2:0] IDX_MAG3  = 3'd6;
  localparam logic [2:0] IDX_END   = 3'd7;

  // Configuration
  logic [7:0]  dev_addr_q;
  logic [31:0] circ_q;

  // Parser
  logic [2:0]  byte_idx_q, byte_idx_d;
  logic        sign_nz_q;
  logic [31:0] raw_q;
  logic        s_acc;
  logic        frame_done;
  logic signed [32:0] pos_now;

  // Odometer state
  logic                      have_base_q;
  logic signed [32:0]        last_pos_q;
  logic [DISTANCE_WIDTH-1:0] total_q, total_d;
  logic signed [63:0]        total_ext;

  // Pipeline
  spfo_pkg::stage_t st_q [1:NS];
  spfo_pkg::stage_t nxt  [1:NS];
  logic [NS:1]   v_q;
  logic [NS+1:1] rdy;
  logic          o_valid_q;
  logic          o_load;
  logic [spfo_pkg::RES_W-1:0] o_data_q;
  logic          o_user_q;
  logic [65:0]   prod_sum;
  logic [49:0]   sat_mag;

  assign cfg_ready_o   = 1'b1;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (byte_idx_q != IDX_END) || rdy[1];
  assign frame_done    = s_acc && (byte_idx_q == IDX_END) &&
                         (s_axis_tdata == spfo_pkg::END_BYTE);

  // Sign-magnitude to two's complement; negative zero lands on zero
  assign pos_now = sign_nz_q ? (33'sd0 - signed'({1'b0, raw_q}))
                             : signed'({1'b0, raw_q});

  // Stage ready chain: a stage loads when empty or when it drains forward
  always_comb begin
    rdy[NS+1] = !o_valid_q || m_axis_tready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign o_load = rdy[NS+1] && v_q[NS];

  // Parser next index
  always_comb begin
    byte_idx_d = byte_idx_q;
    unique case (byte_idx_q) inside
      IDX_ADDR: begin
        if (s_axis_tdata == dev_addr_q) byte_idx_d = IDX_CMD;
      end
      IDX_CMD: begin
        // a wrong command byte drops the frame without being retried as address
        byte_idx_d = (s_axis_tdata == spfo_pkg::CMD_BYTE) ? IDX_SIGN : IDX_ADDR;
      end
      IDX_SIGN, [IDX_MAG0:IDX_MAG3]: begin
        byte_idx_d = byte_idx_q + 3'd1;
      end
      default: begin
        byte_idx_d = IDX_ADDR;
      end
    endcase
  end

  // Stage work
  always_comb begin
    // intake: position, baseline flag and the previous position
    nxt[1]      = '0;
    nxt[1].pos  = pos_now;
    nxt[1].base = !have_base_q;
    nxt[1].prev = last_pos_q;

    // raw change; baseline frames carry zero through the rest
    nxt[2] = st_q[1];
    nxt[2].delta = st_q[1].base ? 34'sd0
                 : (34'(st_q[1].pos) - 34'(st_q[1].prev));

    // one wrap correction at half a turn
    nxt[3] = st_q[2];
    if (st_q[2].delta > spfo_pkg::HALF_TURN) begin
      nxt[3].delta = st_q[2].delta - spfo_pkg::TURN_COUNTS;
    end else if (st_q[2].delta < -spfo_pkg::HALF_TURN) begin
      nxt[3].delta = st_q[2].delta + spfo_pkg::TURN_COUNTS;
    end

    // magnitude and sign
    nxt[4]     = st_q[3];
    nxt[4].neg = st_q[3].delta[33];
    nxt[4].mag = st_q[3].delta[33] ? 34'(-st_q[3].delta) : 34'(st_q[3].delta);

    // partial products of magnitude times circumference
    nxt[5]      = st_q[4];
    nxt[5].p_lo = 49'(st_q[4].mag[16:0]) * 49'(circ_q);
    nxt[5].p_hi = 49'(st_q[4].mag[33:17]) * 49'(circ_q);

    // sum and drop the per-turn divisor bits (truncation)
    nxt[6]        = st_q[5];
    prod_sum      = {st_q[5].p_hi, 17'b0} + 66'(st_q[5].p_lo);
    nxt[6].scaled = prod_sum[65:spfo_pkg::TURN_SHIFT];

    // saturate into the 37-bit signed range and apply sign
    nxt[7] = st_q[6];
    if (st_q[6].neg) begin
      sat_mag = (st_q[6].scaled > spfo_pkg::LEN_NEG_MAX) ? spfo_pkg::LEN_NEG_MAX
                                                         : st_q[6].scaled;
      nxt[7].dlen = 37'sd0 - signed'(sat_mag[36:0]);
    end else begin
      sat_mag = (st_q[6].scaled > spfo_pkg::LEN_POS_MAX) ? spfo_pkg::LEN_POS_MAX
                                                         : st_q[6].scaled;
      nxt[7].dlen = signed'({1'b0, sat_mag[35:0]});
    end
  end

  // Running total, wrapped in DISTANCE_WIDTH bits
  assign total_d   = total_q + DISTANCE_WIDTH'(signed'(st_q[NS].dlen));
  assign total_ext = 64'(signed'(total_d));

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= spfo_pkg::DEVICE_ADDRESS_RST;
      circ_q      <= spfo_pkg::CIRCUMFERENCE_RST;
      byte_idx_q  <= IDX_ADDR;
      sign_nz_q   <= 1'b0;
      have_base_q <= 1'b0;
      last_pos_q  <= '0;
      total_q     <= '0;
      v_q         <= '0;
      o_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          spfo_pkg::CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data_i[7:0];
          spfo_pkg::CFG_CIRCUMFERENCE:  circ_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_acc) begin
        byte_idx_q <= byte_idx_d;
        if (byte_idx_q == IDX_SIGN) sign_nz_q <= (s_axis_tdata != 8'd0);
      end
      if (frame_done) begin
        have_base_q <= 1'b1;
        last_pos_q  <= pos_now;
      end
      if (rdy[1]) v_q[1] <= frame_done;
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
      if (rdy[NS+1]) o_valid_q <= v_q[NS];
      if (o_load) total_q <= total_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc && (byte_idx_q >= IDX_MAG0) && (byte_idx_q <= IDX_MAG3)) begin
      raw_q <= {raw_q[23:0], s_axis_tdata};
    end
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k]) st_q[k] <= nxt[k];
    end
    if (o_load) begin
      o_data_q <= {total_ext[spfo_pkg::TOTAL_W-1:0], st_q[NS].dlen,
                   st_q[NS].delta, st_q[NS].pos};
      o_user_q <= st_q[NS].base;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tuser  = o_user_q;

endmodule
`default_nettype wire

// ===== hw/rtl/spfo_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper position frame odometer checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module spfo_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [spfo_pkg::RES_W-1:0]          m_axis_tdata,
  input wire logic                                m_axis_tuser
);

  logic [33:0] delta_f;
  logic [36:0] dlen_f;

  assign delta_f = m_axis_tdata[spfo_pkg::DLEN_LSB-1:spfo_pkg::DELTA_LSB];
  assign dlen_f  = m_axis_tdata[spfo_pkg::TOTAL_LSB-1:spfo_pkg::DLEN_LSB];

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Baseline frame moves nothing
  a_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (delta_f == '0) && (dlen_f == '0))
    else $error("baseline frame with nonzero delta or length");

  // No change in counts gives no length
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (delta_f == '0) |-> (dlen_f == '0))
    else $error("length without count change");

  // Forward count change never gives a negative length
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !delta_f[33] |-> !dlen_f[36])
    else $error("negative length for forward motion");

endmodule

bind stepper_position_frame_odometer_top spfo_checker u_spfo_checker (.*);
`default_nettype wire
